// ----- rtl/core/pds_pkg.sv -----
// ----------------------------------------------------------------------------
// pds_pkg
// Types and constants shared by the PLL divider search blocks.
// ----------------------------------------------------------------------------
package pds_pkg;

  localparam int REF_W = 25;
  localparam int THR_W = 28;
  localparam int TGT_W = 28;
  localparam int NUM_W = 7;
  localparam int DEN_W = 5;
  localparam int FRQ_W = 32;
  localparam int CIDX_W = 4;
  localparam int CDAT_W = 28;
  localparam int DIV_STAGES = 4;
  localparam int DIV_BITS = FRQ_W / DIV_STAGES;

  localparam logic [NUM_W-1:0] DEF_NUM = 7'd69;
  localparam logic [DEN_W-1:0] DEF_DEN = 5'd24;
  localparam logic [REF_W-1:0] REF_RST = 25'd14318180;
  localparam logic [THR_W-1:0] THR_RST = 28'd40000000;

  localparam logic [CIDX_W-1:0] CFG_REF = 4'd0;
  localparam logic [CIDX_W-1:0] CFG_THR = 4'd1;

  typedef struct packed {
    logic [TGT_W-1:0] target_hz;
  } in_word_t;

  typedef struct packed {
    logic [NUM_W-1:0] numerator;
    logic [DEN_W-1:0] denominator;
    logic             post_select;
    logic [FRQ_W-1:0] achieved_hz;
  } out_word_t;

  typedef struct packed {
    logic [CIDX_W-1:0] index;
    logic [CDAT_W-1:0] value;
  } cfg_word_t;

  // one candidate pair in flight
  typedef struct packed {
    logic             vld;
    logic             seed;
    logic             last;
    logic [NUM_W-1:0] n;
    logic [DEN_W-1:0] d;
    logic             p;
    logic [TGT_W-1:0] target;
  } cand_t;

  typedef struct packed {
    cand_t            c;
    logic [FRQ_W-1:0] x;    // dividend bits shift out, quotient bits shift in
    logic [DEN_W-1:0] rem;
  } div_t;

endpackage

// ----- rtl/core/pds_stream_if.sv -----
// ----------------------------------------------------------------------------
// pds_stream_if
// Valid/ready channel carrying one word of type T.
// ----------------------------------------------------------------------------
interface pds_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/pll_divider_search.sv -----
// ----------------------------------------------------------------------------
// pll_divider_search
// Brute-force search of PLL numerator/denominator for a target frequency.
// ----------------------------------------------------------------------------
//  channel  dir  word        contents
//  in_ch    in   in_word_t   target_hz
//  out_ch   out  out_word_t  numerator, denominator, post_select, achieved_hz
//  cfg_ch   in   cfg_word_t  index, value (0 reference_hz, 1 threshold)
//
// One pair per cycle unless the output stalls: a word sends the default pair,
// then every n/d pair, through the single multiply/divide pipe; words run
// back to back. Each pair passes the generator register, the multiply, four
// divider slices and the compare, which registers the result word.
// rst_n is synchronous; config regs return to their reset values.
// A waiting result stalls the whole pipe; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module pll_divider_search #(
  parameter int NUM_LIMIT = 127,
  parameter int DEN_LIMIT = 31
) (
  input logic clk,
  input logic rst_n,
  pds_stream_if.sink   in_ch,
  pds_stream_if.source out_ch,
  pds_stream_if.sink   cfg_ch
);
  import pds_pkg::*;

  logic [REF_W-1:0] ref_r;
  logic [THR_W-1:0] thr_r;
  logic             en;
  cand_t            gen_c;
  div_t             dv [DIV_STAGES+1];
  in_word_t         in_w;
  cfg_word_t        cfg_w;
  out_word_t        out_w;

  assign in_w         = in_ch.data;
  assign cfg_w        = cfg_ch.data;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.data  = out_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r <= REF_RST;
      thr_r <= THR_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_w.index)
        CFG_REF: ref_r <= cfg_w.value[REF_W-1:0];
        CFG_THR: thr_r <= cfg_w.value[THR_W-1:0];
        default: ;
      endcase
    end
  end

  pds_gen #(.NUM_LIMIT(NUM_LIMIT), .DEN_LIMIT(DEN_LIMIT)) u_gen (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_target(in_w.target_hz), .thr(thr_r), .c_r(gen_c)
  );

  pds_mul u_mul (
    .clk(clk), .rst_n(rst_n), .en(en), .ref_hz(ref_r), .c_i(gen_c), .q_r(dv[0])
  );

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    pds_div_stage u_div (
      .clk(clk), .rst_n(rst_n), .en(en), .s_i(dv[g]), .s_r(dv[g+1])
    );
  end

  pds_acc u_acc (
    .clk(clk), .rst_n(rst_n), .s_i(dv[DIV_STAGES]), .en(en),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_w)
  );

  a_rst_clear: assert property (@(posedge clk) !rst_n |=> !out_ch.valid)
    else $error("result valid after reset");
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |-> !in_ch.ready)
    else $error("input taken while pipe stalled");
  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_w.denominator != '0 && out_w.numerator != '0)
    else $error("zero divider in result");
endmodule

// ----- rtl/core/pds_gen.sv -----
// ----------------------------------------------------------------------------
// pds_gen
// Issues the default pair, then every n/d pair, one per enabled cycle.
// ----------------------------------------------------------------------------
module pds_gen #(
  parameter int NUM_LIMIT = 127,
  parameter int DEN_LIMIT = 31
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [pds_pkg::TGT_W-1:0] in_target,
  input  logic [pds_pkg::THR_W-1:0] thr,
  output pds_pkg::cand_t         c_r
);
  import pds_pkg::*;

  logic             busy_r, busy_nxt;
  logic             seed_r, seed_nxt;
  logic [NUM_W-1:0] n_r, n_nxt;
  logic [DEN_W-1:0] d_r, d_nxt;
  logic [TGT_W-1:0] tgt_r, tgt_nxt;
  logic             p_r, p_nxt;
  logic             is_last;
  logic             acc;
  cand_t            c_nxt;

  assign is_last  = busy_r && !seed_r && (n_r == NUM_W'(NUM_LIMIT))
                    && (d_r == DEN_W'(DEN_LIMIT));
  assign in_ready = en && (!busy_r || is_last);
  assign acc      = in_valid && in_ready;

  always_comb begin
    busy_nxt = busy_r;
    seed_nxt = seed_r;
    n_nxt    = n_r;
    d_nxt    = d_r;
    tgt_nxt  = tgt_r;
    p_nxt    = p_r;
    c_nxt    = c_r;
    if (en) begin
      c_nxt.vld    = busy_r;
      c_nxt.seed   = seed_r;
      c_nxt.last   = is_last;
      c_nxt.n      = seed_r ? DEF_NUM : n_r;
      c_nxt.d      = seed_r ? DEF_DEN : d_r;
      c_nxt.p      = p_r;
      c_nxt.target = tgt_r;
      if (busy_r) begin
        seed_nxt = 1'b0;
        if (seed_r) begin
          n_nxt = NUM_W'(1);
          d_nxt = DEN_W'(1);
        end else if (d_r == DEN_W'(DEN_LIMIT)) begin
          d_nxt = DEN_W'(1);
          n_nxt = n_r + NUM_W'(1);
        end else begin
          d_nxt = d_r + DEN_W'(1);
        end
        if (is_last) busy_nxt = 1'b0;
      end
      if (acc) begin
        busy_nxt = 1'b1;
        seed_nxt = 1'b1;
        tgt_nxt  = in_target;
        p_nxt    = (in_target < thr);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      seed_r <= 1'b0;
      c_r.vld <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      seed_r <= seed_nxt;
      c_r.vld <= c_nxt.vld;
    end
    n_r   <= n_nxt;
    d_r   <= d_nxt;
    tgt_r <= tgt_nxt;
    p_r   <= p_nxt;
    c_r.seed   <= c_nxt.seed;
    c_r.last   <= c_nxt.last;
    c_r.n      <= c_nxt.n;
    c_r.d      <= c_nxt.d;
    c_r.p      <= c_nxt.p;
    c_r.target <= c_nxt.target;
  end
endmodule

// ----- rtl/core/pds_mul.sv -----
// ----------------------------------------------------------------------------
// pds_mul
// Forms reference times numerator for the divider.
// ----------------------------------------------------------------------------
module pds_mul (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic [pds_pkg::REF_W-1:0] ref_hz,
  input  pds_pkg::cand_t            c_i,
  output pds_pkg::div_t             q_r
);
  import pds_pkg::*;

  logic [FRQ_W-1:0] prod;

  assign prod = FRQ_W'(ref_hz) * FRQ_W'(c_i.n);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.c.vld <= 1'b0;
    end else if (en) begin
      q_r.c.vld <= c_i.vld;
    end
    if (en) begin
      q_r.c.seed   <= c_i.seed;
      q_r.c.last   <= c_i.last;
      q_r.c.n      <= c_i.n;
      q_r.c.d      <= c_i.d;
      q_r.c.p      <= c_i.p;
      q_r.c.target <= c_i.target;
      q_r.x        <= prod;
      q_r.rem      <= '0;
    end
  end
endmodule

// ----- rtl/core/pds_div_stage.sv -----
// ----------------------------------------------------------------------------
// pds_div_stage
// One slice of the restoring divider: DIV_BITS quotient bits per stage.
// ----------------------------------------------------------------------------
module pds_div_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  pds_pkg::div_t s_i,
  output pds_pkg::div_t s_r
);
  import pds_pkg::*;

  div_t           s_nxt;
  logic [DEN_W:0] t;

  always_comb begin
    s_nxt = s_i;
    t     = '0;
    for (int i = 0; i < DIV_BITS; i++) begin
      t       = {s_nxt.rem, s_nxt.x[FRQ_W-1]};
      s_nxt.x = {s_nxt.x[FRQ_W-2:0], 1'b0};
      if (t >= {1'b0, s_nxt.c.d}) begin
        s_nxt.rem  = DEN_W'(t - {1'b0, s_nxt.c.d});
        s_nxt.x[0] = 1'b1;
      end else begin
        s_nxt.rem = t[DEN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r.c.vld <= 1'b0;
    end else if (en) begin
      s_r.c.vld <= s_nxt.c.vld;
    end
    if (en) begin
      s_r.c.seed   <= s_nxt.c.seed;
      s_r.c.last   <= s_nxt.c.last;
      s_r.c.n      <= s_nxt.c.n;
      s_r.c.d      <= s_nxt.c.d;
      s_r.c.p      <= s_nxt.c.p;
      s_r.c.target <= s_nxt.c.target;
      s_r.x        <= s_nxt.x;
      s_r.rem      <= s_nxt.rem;
    end
  end
endmodule

// ----- rtl/core/pds_acc.sv -----
// ----------------------------------------------------------------------------
// pds_acc
// Error compare, best-pair tracking and the output word register.
// ----------------------------------------------------------------------------
module pds_acc (
  input  logic               clk,
  input  logic               rst_n,
  input  pds_pkg::div_t      s_i,
  output logic               en,
  output logic               out_valid,
  input  logic               out_ready,
  output pds_pkg::out_word_t out_data
);
  import pds_pkg::*;

  logic [FRQ_W-1:0] q, tgt, err;
  logic [FRQ_W-1:0] best_err_r, best_err_nxt;
  logic [FRQ_W-1:0] best_q_r, best_q_nxt;
  logic [NUM_W-1:0] best_n_r, best_n_nxt;
  logic [DEN_W-1:0] best_d_r, best_d_nxt;
  logic             ov_r, ov_nxt;
  out_word_t        od_r, od_nxt;

  assign en  = !ov_r || out_ready;
  // divide by 2d is the quotient by d halved
  assign q   = s_i.c.p ? {1'b0, s_i.x[FRQ_W-1:1]} : s_i.x;
  assign tgt = FRQ_W'(s_i.c.target);
  assign err = (tgt >= q) ? (tgt - q) : (q - tgt);

  always_comb begin
    best_err_nxt = best_err_r;
    best_q_nxt   = best_q_r;
    best_n_nxt   = best_n_r;
    best_d_nxt   = best_d_r;
    ov_nxt       = ov_r && !out_ready;
    od_nxt       = od_r;
    if (en && s_i.c.vld) begin
      if (s_i.c.seed) begin
        best_err_nxt = tgt;
        best_q_nxt   = q;
        best_n_nxt   = s_i.c.n;
        best_d_nxt   = s_i.c.d;
      end else if (err <= best_err_r) begin
        best_err_nxt = err;
        best_q_nxt   = q;
        best_n_nxt   = s_i.c.n;
        best_d_nxt   = s_i.c.d;
      end
      if (s_i.c.last) begin
        ov_nxt             = 1'b1;
        od_nxt.numerator   = best_n_nxt;
        od_nxt.denominator = best_d_nxt;
        od_nxt.post_select = s_i.c.p;
        od_nxt.achieved_hz = best_q_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
    end
    best_err_r <= best_err_nxt;
    best_q_r   <= best_q_nxt;
    best_n_r   <= best_n_nxt;
    best_d_r   <= best_d_nxt;
    od_r       <= od_nxt;
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;
endmodule

// ----- test/pll_divider_search_tb.sv -----
// ----------------------------------------------------------------------------
// pll_divider_search_tb
// Checks the PLL divider search against an in-bench brute-force predictor.
// Target words go in with random gaps and results come out with random
// stalls. The reference and threshold registers are rewritten between
// phases, including their extremes.
// ----------------------------------------------------------------------------
module pll_divider_search_tb;
  import pds_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_MAX  = 127;
  localparam int DEN_MAX  = 31;
  localparam int IDLE_LIM = 40000;

  typedef struct {
    logic [TGT_W-1:0] target;
    bit               hold;   // wait for the pipe to drain before sending
  } pend_word_t;

  logic clk;
  logic rst_n;

  pds_stream_if #(.T(in_word_t))  in_if ();
  pds_stream_if #(.T(out_word_t)) out_if ();
  pds_stream_if #(.T(cfg_word_t)) cfg_if ();

  pll_divider_search dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  logic [REF_W-1:0] ref_hz;
  logic [THR_W-1:0] thr_hz;
  pend_word_t       pend_q[$];
  out_word_t        setting_q[$];
  int               n_errors;
  int               n_sent;
  int               n_seen;
  int               idle_cycles;
  bit               in_burst;

  function automatic logic [63:0] synth_hz(logic [REF_W-1:0] r, int n, int d, bit p);
    return (64'(r) * 64'(n)) / (64'(d) * (p ? 64'd2 : 64'd1));
  endfunction

  function automatic out_word_t search_divider(logic [TGT_W-1:0] tgt);
    out_word_t   w;
    logic [63:0] t;
    logic [63:0] q;
    logic [63:0] err;
    logic [63:0] best;
    int          bn;
    int          bd;
    bit          p;
    t = 64'(tgt);
    p = (tgt >= thr_hz) ? 1'b0 : 1'b1;
    best = t;
    bn = int'(DEF_NUM);
    bd = int'(DEF_DEN);
    for (int n = 1; n <= NUM_MAX; n++) begin
      for (int d = 1; d <= DEN_MAX; d++) begin
        q = synth_hz(ref_hz, n, d, p);
        err = (t >= q) ? t - q : q - t;
        // ties go to the later pair
        if (err <= best) begin
          best = err;
          bn = n;
          bd = d;
        end
      end
    end
    w.numerator   = NUM_W'(bn);
    w.denominator = DEN_W'(bd);
    w.post_select = p;
    w.achieved_hz = FRQ_W'(synth_hz(ref_hz, bn, bd, p));
    return w;
  endfunction

  function automatic int draw_gap();
    if (in_burst) return 0;
    return ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(0, 15));
  endfunction

  // driver
  always @(posedge clk) begin : drv
    int         gap;
    pend_word_t pw;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      gap = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        setting_q.push_back(search_divider(in_if.data.target_hz));
        n_sent++;
      end
      if (!(in_if.valid && !in_if.ready)) begin
        if (gap > 0) begin
          gap--;
          in_if.valid <= 1'b0;
        end else if (pend_q.size() > 0 && (!pend_q[0].hold || setting_q.size() == 0)) begin
          pw = pend_q.pop_front();
          in_if.data.target_hz <= pw.target;
          in_if.valid <= 1'b1;
          gap = draw_gap();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : mon
    int        stall;
    out_word_t ex;
    out_word_t got;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      stall = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got = out_if.data;
        n_seen++;
        if (setting_q.size() == 0) begin
          $display("%0t: unexpected word n=%0d d=%0d p=%0d hz=%0d", $time,
                   got.numerator, got.denominator, got.post_select, got.achieved_hz);
          n_errors++;
        end else begin
          ex = setting_q.pop_front();
          if (got.numerator !== ex.numerator) begin
            $display("%0t: numerator exp %0d got %0d", $time, ex.numerator, got.numerator);
            n_errors++;
          end
          if (got.denominator !== ex.denominator) begin
            $display("%0t: denominator exp %0d got %0d", $time,
                     ex.denominator, got.denominator);
            n_errors++;
          end
          if (got.post_select !== ex.post_select) begin
            $display("%0t: post_select exp %0d got %0d", $time,
                     ex.post_select, got.post_select);
            n_errors++;
          end
          if (got.achieved_hz !== ex.achieved_hz) begin
            $display("%0t: achieved_hz exp %0d got %0d", $time,
                     ex.achieved_hz, got.achieved_hz);
            n_errors++;
          end
        end
        stall = draw_gap();
      end else if (stall > 0) begin
        stall--;
      end
      out_if.ready <= (stall == 0);
    end
  end

  // watchdog: cycles with no word moving on any channel
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIM) begin
      $display("pll_divider_search: mismatch");
      $finish;
    end
  end

  task automatic push_target(logic [TGT_W-1:0] t, bit hold = 1'b0);
    pend_word_t pw;
    pw.target = t;
    pw.hold = hold;
    pend_q.push_back(pw);
  endtask

  task automatic drain();
    while (pend_q.size() > 0 || in_if.valid || setting_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CIDX_W-1:0] idx, logic [CDAT_W-1:0] val);
    cfg_if.data.index <= idx;
    cfg_if.data.value <= val;
    cfg_if.valid <= 1'b1;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    if (idx == CFG_REF) ref_hz = val[REF_W-1:0];
    else if (idx == CFG_THR) thr_hz = val[THR_W-1:0];
  endtask

  task automatic random_targets(int cnt);
    logic [TGT_W-1:0] t;
    for (int i = 0; i < cnt; i++) begin
      case ($urandom_range(0, 3))
        0: t = TGT_W'($urandom());
        1: t = TGT_W'($urandom_range(0, 200000000));
        2: t = TGT_W'(thr_hz + $urandom_range(0, 4) - 2);
        default: t = TGT_W'(synth_hz(ref_hz, int'($urandom_range(1, NUM_MAX)),
                                     int'($urandom_range(1, DEN_MAX)),
                                     1'($urandom_range(0, 1)))
                            + $urandom_range(0, 8) - 4);
      endcase
      push_target(t, i == cnt / 2);
    end
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    n_errors = 0;
    n_sent = 0;
    n_seen = 0;
    idle_cycles = 0;
    in_burst = 0;
    ref_hz = REF_RST;
    thr_hz = THR_RST;
    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset config: zero target, top target, around the threshold, typical and bit-pattern targets
    push_target('0);
    push_target('1);
    push_target(28'd1);
    push_target(THR_RST - 28'd1);
    push_target(THR_RST);
    push_target(28'd25175000);
    push_target(28'd65000000);
    push_target(28'h5555555);
    push_target(28'hAAAAAAA);
    drain();

    // largest reference, threshold zero: always divide by one
    cfg_write(CFG_REF, 28'(25'h1FFFFFF));
    cfg_write(CFG_THR, '0);
    push_target('0);
    push_target('1);
    push_target(28'd33554431);
    drain();

    // reference one, top threshold: divide by two for all but the top target
    cfg_write(CFG_REF, 28'd1);
    cfg_write(CFG_THR, '1);
    push_target('0);
    push_target(28'd63);
    push_target('1);
    drain();

    // zero reference: every quotient is zero
    cfg_write(CFG_REF, '0);
    push_target(28'd1000);
    push_target('0);
    drain();

    // random, several settings
    cfg_write(CFG_REF, CDAT_W'(REF_RST));
    cfg_write(CFG_THR, THR_RST);
    random_targets(35);
    drain();
    in_burst = 1;
    cfg_write(CFG_REF, 28'(25'h1FFFFFF));
    cfg_write(CFG_THR, 28'd100000000);
    random_targets(20);
    drain();
    in_burst = 0;
    cfg_write(CFG_REF, CDAT_W'($urandom_range(1, 33554431)));
    cfg_write(CFG_THR, CDAT_W'($urandom()));
    random_targets(40);
    drain();
    cfg_write(CFG_REF, 28'd1);
    cfg_write(CFG_THR, '0);
    random_targets(15);
    drain();
    cfg_write(CFG_REF, 28'd27000000);
    cfg_write(CFG_THR, '1);
    random_targets(15);
    drain();

    $display("sent %0d target words over 9 register settings, %0d results checked",
             n_sent, n_seen);
    $display("covered zero and full-scale targets, threshold edges, zero and max reference");
    if (n_errors == 0 && setting_q.size() == 0) begin
      $display("pll_divider_search: match");
    end else begin
      $display("pll_divider_search: mismatch");
    end
    $finish;
  end

endmodule
